// ----- rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, status codes and the character map shared by the base64 decoder
// and its checker.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CharWidth  = 8;
  localparam int CountWidth = 16;
  localparam int StatWidth  = 3;

  // Verdict codes carried on the status field
  localparam logic [StatWidth-1:0] ST_OK       = 3'd0;
  localparam logic [StatWidth-1:0] ST_BAD_CHAR = 3'd1;
  localparam logic [StatWidth-1:0] ST_BAD_PAD  = 3'd2;
  localparam logic [StatWidth-1:0] ST_LENGTH   = 3'd3;
  localparam logic [StatWidth-1:0] ST_CAPACITY = 3'd4;

  // Alphabet boundaries and offsets
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] OFS_LOWER  = 8'd26;
  localparam logic [7:0] OFS_DIGIT  = 8'd52;
  localparam logic [5:0] SX_PLUS    = 6'd62;
  localparam logic [5:0] SX_SLASH   = 6'd63;

  localparam logic [CountWidth-1:0] MAX_BYTES_RESET = 16'd64;

  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  carries_byte;
    logic                  last;
    logic [StatWidth-1:0]  status;
    logic [CountWidth-1:0] total_bytes;
  } out_item_t;

  typedef struct packed {
    logic       is_pad;
    logic       is_bad;
    logic [5:0] value;
  } sextet_t;

  // Map one ASCII character to its sextet, or flag padding / bad character
  function automatic sextet_t sextet_of(logic [CharWidth-1:0] ch);
    sextet_t s;
    s.is_pad = 1'b0;
    s.is_bad = 1'b0;
    s.value  = 6'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      s.value = 6'(ch - CH_UPPER_A);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      s.value = 6'(ch - CH_LOWER_A + OFS_LOWER);
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      s.value = 6'(ch - CH_DIGIT_0 + OFS_DIGIT);
    end else if (ch == CH_PLUS) begin
      s.value = SX_PLUS;
    end else if (ch == CH_SLASH) begin
      s.value = SX_SLASH;
    end else if (ch == CH_PAD) begin
      s.is_pad = 1'b1;
    end else begin
      s.is_bad = 1'b1;
    end
    return s;
  endfunction

endpackage

// ----- rtl/strict_base64_decoder.sv -----
// Strict base64 decoder. One character item is taken per cycle while the result
// register has room; its decode, padding and capacity checks are done in a
// single pass and the item's results (zero to three) land in a three-entry
// result register that drains one result per cycle on the output channel
// while the receiver is ready. A new character is taken in the same cycle the
// last pending result leaves, so the result register, not the decode, limits
// the rate: it takes a new item only when at most one result is left and that
// one is leaving. No clearing pass follows reset. The capacity register is
// written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
// strict_base64_decoder
// Decodes RFC 4648 base64 text with mandatory padding, one char per item,
// and closes each string with a verdict and byte total.
// ----------------------------------------------------------------------------
module strict_base64_decoder
  import b64d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CountWidth-1:0] cfg_data
);

  // Configuration and per-string state
  logic [CountWidth-1:0] max_bytes;
  logic [1:0]            qpos;
  logic [17:0]           acc;
  logic [1:0]            pad_cnt;
  logic [StatWidth-1:0]  fault;
  logic [CountWidth-1:0] emitted;

  // Result register: entry 0 is the one shown on the output
  out_item_t             rbuf [3];
  logic [1:0]            rcnt;

  // Next values from the decode pass
  logic [1:0]            qpos_next;
  logic [17:0]           acc_next;
  logic [1:0]            pad_next;
  logic [StatWidth-1:0]  fault_next;
  logic [CountWidth-1:0] emitted_next;
  out_item_t             res_next [3];
  logic [1:0]            cnt_next;

  logic in_fire;
  logic out_fire;

  assign cfg_ready = 1'b1;
  assign out_valid = (rcnt != 2'd0);
  assign out_data  = rbuf[0];
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (rcnt == 2'd0) || (rcnt == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;

  // Decode one character against the current quantum
  always_comb begin
    sextet_t               sx;
    logic                  do_finish;
    logic [5:0]            fourth;
    logic [23:0]           word;
    logic [1:0]            nbytes;
    logic [CountWidth:0]   sum;
    logic                  eos;

    sx           = sextet_of(in_data.char_code);
    eos          = in_data.end_of_string;
    qpos_next    = qpos;
    acc_next     = acc;
    pad_next     = pad_cnt;
    fault_next   = fault;
    emitted_next = emitted;
    cnt_next     = 2'd0;
    do_finish    = 1'b0;
    fourth       = 6'd0;
    for (int i = 0; i < 3; i++) begin
      res_next[i] = '0;
    end

    if (fault == ST_OK) begin
      if (pad_cnt != 2'd0) begin
        if (!sx.is_pad) begin
          fault_next = ST_BAD_PAD;
        end else begin
          pad_next  = 2'd2;
          do_finish = 1'b1;
        end
      end else if (sx.is_pad) begin
        if (qpos < 2'd2) begin
          fault_next = ST_BAD_PAD;
        end else if (qpos == 2'd2) begin
          pad_next  = 2'd1;
          acc_next  = {acc[11:0], 6'd0};
          qpos_next = 2'd3;
        end else begin
          pad_next  = 2'd1;
          do_finish = 1'b1;
        end
      end else if (sx.is_bad) begin
        fault_next = ST_BAD_CHAR;
      end else if (qpos < 2'd3) begin
        acc_next  = {acc[11:0], sx.value};
        qpos_next = qpos + 2'd1;
      end else begin
        fourth    = sx.value;
        do_finish = 1'b1;
      end
    end

    // Complete the quantum: check padding and capacity, then emit bytes
    word   = {acc, fourth};
    nbytes = 2'd3 - pad_next;
    sum    = {1'b0, emitted} + {{(CountWidth-1){1'b0}}, nbytes};
    if (do_finish) begin
      if (pad_next != 2'd0 && !eos) begin
        fault_next = ST_BAD_PAD;
      end else if (sum > {1'b0, max_bytes}) begin
        fault_next = ST_CAPACITY;
      end else begin
        res_next[0].data_byte    = word[23:16];
        res_next[1].data_byte    = word[15:8];
        res_next[2].data_byte    = word[7:0];
        res_next[0].carries_byte = 1'b1;
        res_next[1].carries_byte = 1'b1;
        res_next[2].carries_byte = 1'b1;
        cnt_next                 = nbytes;
        emitted_next             = sum[CountWidth-1:0];
      end
      qpos_next = 2'd0;
      acc_next  = '0;
      pad_next  = 2'd0;
    end

    // Close the string: verdict item on a fault or with no byte to tag, else tag the final byte
    if (eos) begin
      if (fault_next == ST_OK && qpos_next != 2'd0) begin
        fault_next = ST_LENGTH;
      end
      if (fault_next != ST_OK || cnt_next == 2'd0) begin
        res_next[0]              = '0;
        res_next[0].last         = 1'b1;
        res_next[0].status       = (fault_next != ST_OK) ? fault_next : ST_LENGTH;
        res_next[0].total_bytes  = emitted_next;
        cnt_next                 = 2'd1;
      end else begin
        case (cnt_next)
          2'd1: begin
            res_next[0].last        = 1'b1;
            res_next[0].total_bytes = emitted_next;
          end
          2'd2: begin
            res_next[1].last        = 1'b1;
            res_next[1].total_bytes = emitted_next;
          end
          2'd3: begin
            res_next[2].last        = 1'b1;
            res_next[2].total_bytes = emitted_next;
          end
          default: begin
            res_next[0].last = 1'b0;
          end
        endcase
      end
      qpos_next    = 2'd0;
      acc_next     = '0;
      pad_next     = 2'd0;
      fault_next   = ST_OK;
      emitted_next = '0;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_bytes <= cfg_data;
    end
  end

  // Advance per-string state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      qpos    <= 2'd0;
      acc     <= '0;
      pad_cnt <= 2'd0;
      fault   <= ST_OK;
      emitted <= '0;
    end else if (in_fire) begin
      qpos    <= qpos_next;
      acc     <= acc_next;
      pad_cnt <= pad_next;
      fault   <= fault_next;
      emitted <= emitted_next;
    end
  end

  // Result occupancy: load on accept, drop one on each output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= 2'd0;
    end else if (in_fire) begin
      rcnt <= cnt_next;
    end else if (out_fire) begin
      rcnt <= rcnt - 2'd1;
    end
  end

  // Result payload: load or shift toward the output slot
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rbuf[0] <= res_next[0];
      rbuf[1] <= res_next[1];
      rbuf[2] <= res_next[2];
    end else if (out_fire) begin
      rbuf[0] <= rbuf[1];
      rbuf[1] <= rbuf[2];
    end
  end

endmodule

// ----- rtl/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker
  import b64d_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // Keep verdict and total zero on results that do not close a string
  a_mid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> out_data.status == ST_OK &&
      out_data.total_bytes == '0)
    else $error("status or total set on a non-final result");

  // A status-only item always closes the string with a fault verdict
  a_status_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.carries_byte |-> out_data.last &&
      out_data.status != ST_OK && out_data.data_byte == 8'd0)
    else $error("malformed status item");

  // A decoded byte never carries a fault
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.carries_byte |-> out_data.status == ST_OK)
    else $error("fault reported on a data byte");

endmodule

bind strict_base64_decoder b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/tb_strict_base64_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strict_base64_decoder
// Self-checking bench for the strict base64 decoder. A queue of characters
// feeds a bursty driver and an item-level decode model predicts every byte
// and verdict item. A monitor compares each result against the model while
// the receiver stalls on its own pattern and the capacity register is swept
// across its range between phases.
// ----------------------------------------------------------------------------
module tb_strict_base64_decoder;
  import b64d_pkg::*;

  localparam int SX_BAD_MARK = 64;
  localparam int SX_PAD_MARK = 65;
  localparam int ITEM_TARGET = 410;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CountWidth-1:0] cfg_data = '0;

  // Characters waiting to be sent and decode results waiting to arrive
  in_item_t  char_queue[$];
  out_item_t decoded_queue[$];
  logic [7:0] str_buf[$];
  int items_queued = 0;
  int errors = 0;

  // Decode model state
  logic [1:0]            qpos = '0;
  logic [17:0]           acc = '0;
  logic [1:0]            pads = '0;
  logic [StatWidth-1:0]  fault = ST_OK;
  logic [16:0]           nbytes = '0;
  logic [CountWidth-1:0] capacity = MAX_BYTES_RESET;
  out_item_t             step_buf[3];
  int                    step_n;

  // Driver and receiver pacing
  int       burst_left = 1;
  int       gap_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;
  int       hold_left = 0;
  bit       hold_request = 1'b0;

  strict_base64_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Map a character to 0..63, or to the pad / bad marks
  function automatic int sextet_value(logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c - CH_UPPER_A);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c - CH_LOWER_A) + 26;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c - CH_DIGIT_0) + 52;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    if (c == CH_PAD) return SX_PAD_MARK;
    return SX_BAD_MARK;
  endfunction

  // Alphabet character for a sextet value
  function automatic logic [7:0] char_of(int v);
    if (v < 26) return CH_UPPER_A + 8'(v);
    if (v < 52) return CH_LOWER_A + 8'(v - 26);
    if (v < 62) return CH_DIGIT_0 + 8'(v - 52);
    if (v == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic out_item_t make_result(logic [7:0] b, logic carries, logic fin,
                                            logic [StatWidth-1:0] st,
                                            logic [CountWidth-1:0] total);
    out_item_t r;
    r.data_byte    = b;
    r.carries_byte = carries;
    r.last         = fin;
    r.status       = st;
    r.total_bytes  = total;
    return r;
  endfunction

  // Complete a quantum: emit its bytes, or record a padding or capacity fault
  task automatic close_quantum(logic [5:0] fourth, logic eos);
    logic [23:0] word;
    int n;
    int i;
    word = {acc, fourth};
    n = 3 - int'(pads);
    if (pads != 0 && !eos) begin
      fault = ST_BAD_PAD;
    end else if (int'(nbytes) + n > int'(capacity)) begin
      fault = ST_CAPACITY;
    end else begin
      for (i = 0; i < n; i++) begin
        step_buf[step_n] = make_result(word[23-8*i -: 8], 1'b1, 1'b0, ST_OK, '0);
        step_n++;
      end
      nbytes = nbytes + 17'(n);
    end
    qpos = '0;
    acc  = '0;
    pads = '0;
  endtask

  // Advance the decode model by one accepted character
  task automatic decode_char(in_item_t it);
    int v;
    int i;
    step_n = 0;
    if (fault == ST_OK) begin
      v = sextet_value(it.char_code);
      if (pads != 0) begin
        if (v != SX_PAD_MARK) begin
          fault = ST_BAD_PAD;
        end else begin
          pads = 2'd2;
          close_quantum(6'd0, it.end_of_string);
        end
      end else if (v == SX_PAD_MARK) begin
        if (qpos < 2) begin
          fault = ST_BAD_PAD;
        end else if (qpos == 2) begin
          pads = 2'd1;
          acc  = acc << 6;
          qpos = 2'd3;
        end else begin
          pads = 2'd1;
          close_quantum(6'd0, it.end_of_string);
        end
      end else if (v == SX_BAD_MARK) begin
        fault = ST_BAD_CHAR;
      end else if (qpos < 3) begin
        acc  = {acc[11:0], 6'(v)};
        qpos = qpos + 2'd1;
      end else begin
        close_quantum(6'(v), it.end_of_string);
      end
    end
    // Close the string with a verdict on its final result
    if (it.end_of_string) begin
      if (fault == ST_OK && qpos != 0) fault = ST_LENGTH;
      if (fault != ST_OK || step_n == 0) begin
        step_buf[0] = make_result(8'd0, 1'b0, 1'b1,
                                  (fault != ST_OK) ? fault : ST_LENGTH, nbytes[15:0]);
        step_n = 1;
      end else begin
        step_buf[step_n-1].last        = 1'b1;
        step_buf[step_n-1].total_bytes = nbytes[15:0];
      end
      qpos   = '0;
      acc    = '0;
      pads   = '0;
      fault  = ST_OK;
      nbytes = '0;
    end
    for (i = 0; i < step_n; i++) decoded_queue.push_back(step_buf[i]);
  endtask

  task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Drive characters in bursts; predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_char(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          in_data  <= char_queue.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output on a changing pattern, with an occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(5, 60);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = decoded_queue.pop_front();
        check_field("data_byte", want.data_byte, out_data.data_byte);
        check_field("carries_byte", want.carries_byte, out_data.carries_byte);
        check_field("last", want.last, out_data.last);
        check_field("status", want.status, out_data.status);
        check_field("total_bytes", want.total_bytes, out_data.total_bytes);
      end
    end
  end

  task automatic push_char(logic [7:0] c, logic eos);
    in_item_t it;
    it.char_code     = c;
    it.end_of_string = eos;
    char_queue.push_back(it);
    items_queued++;
  endtask

  // Wait until every character is taken and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (char_queue.size() != 0 || in_valid || decoded_queue.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Send the string in str_buf, flagging its last character; optionally
  // pause halfway until the block has drained
  task automatic emit_string(bit pause_inside);
    int i;
    for (i = 0; i < str_buf.size(); i++) begin
      if (pause_inside && i == str_buf.size() / 2 && i > 0) wait_drained();
      push_char(str_buf[i], i == str_buf.size() - 1);
    end
  endtask

  task automatic load_text(string s);
    int i;
    str_buf.delete();
    for (i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  // Build a well-formed string of random quanta; pad_kind 1 or 2 ends it in
  // one or two pad characters
  task automatic build_valid(int quanta, int pad_kind);
    int i;
    str_buf.delete();
    for (i = 0; i < 4 * quanta - pad_kind; i++) str_buf.push_back(char_of($urandom_range(0, 63)));
    for (i = 0; i < pad_kind; i++) str_buf.push_back(CH_PAD);
  endtask

  // Mostly well-formed strings, some damaged, some plain noise
  task automatic random_string(bit allow_pause);
    int kind;
    int pos;
    int i;
    int quanta;
    kind   = $urandom_range(0, 99);
    quanta = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    build_valid(quanta, $urandom_range(0, 2));
    if (kind >= 85) begin
      str_buf.delete();
      for (i = 0; i < $urandom_range(1, 6); i++) str_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 70) begin
      pos = $urandom_range(0, str_buf.size() - 1);
      case ($urandom_range(0, 4))
        0: str_buf[pos] = 8'($urandom_range(0, 255));
        1: str_buf[pos] = CH_PAD;
        2: if (str_buf.size() > 1) void'(str_buf.pop_back());
        3: str_buf.push_back(char_of($urandom_range(0, 63)));
        default: begin
          // padded quantum ahead of the rest of the string
          str_buf.insert(0, CH_PAD);
          if ($urandom_range(0, 1) == 1) str_buf.insert(0, CH_PAD);
          else str_buf.insert(0, char_of($urandom_range(0, 63)));
          str_buf.insert(0, char_of($urandom_range(0, 63)));
          str_buf.insert(0, char_of($urandom_range(0, 63)));
        end
      endcase
    end
    emit_string(allow_pause && $urandom_range(0, 9) == 0);
  endtask

  task automatic fill_strings(int n_items, bit allow_pause);
    int stop_at;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) random_string(allow_pause);
  endtask

  // Write the capacity register while the block is idle
  task automatic write_capacity(logic [CountWidth-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = value;
  endtask

  initial begin
    int phase;
    logic [CountWidth-1:0] cap_list[7];
    cap_list = '{16'd12, 16'd3, 16'd64, 16'd30, 16'd1, 16'd100, 16'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Alphabet edges, padded endings and the character, padding and length faults at reset capacity
    load_text("AZaz09+/");
    emit_string(1'b0);
    load_text("TQ==");
    emit_string(1'b0);
    load_text("=");
    emit_string(1'b0);
    load_text("A=");
    emit_string(1'b0);
    load_text("AB=?");
    str_buf[3] = 8'hFF;
    emit_string(1'b0);
    load_text("AB==A");
    emit_string(1'b0);
    str_buf.delete();
    str_buf.push_back(8'h00);
    emit_string(1'b0);
    load_text("Q");
    emit_string(1'b0);
    wait_drained();

    // Zero capacity: every full quantum overflows
    write_capacity('0);
    @(negedge clk);
    load_text("QUJD");
    emit_string(1'b0);
    fill_strings(20, 1'b0);
    wait_drained();

    // Largest capacity under a long receiver hold
    write_capacity('1);
    @(negedge clk);
    hold_request = 1'b1;
    fill_strings(70, 1'b0);
    wait_drained();

    // Sweep capacities, with pauses that fall inside strings
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      if (phase % 4 == 3) write_capacity(16'($urandom_range(0, 65535)));
      else write_capacity(cap_list[phase % 7]);
      @(negedge clk);
      fill_strings(45, 1'b1);
      wait_drained();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- strict_base64_decoder.f -----
rtl/b64d_pkg.sv
rtl/strict_base64_decoder.sv
rtl/b64d_checker.sv
tb/tb_strict_base64_decoder.sv
